// ===== rtl/signed_int_to_radix_digits_core_macros.svh =====
// Assertion macros for the checker file of the radix text converter.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SITRD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SITRD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sitrd_pkg.sv =====
// Shared constants, types and helper functions of the radix text converter.
package sitrd_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int CHAR_BITS      = 8;
   localparam int DIGIT_BITS     = 4;
   localparam int RADIX_BITS     = DIGIT_BITS + 1;
   localparam int WORD_BITS      = 64;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [RADIX_BITS-1:0] MIN_RADIX = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] MAX_RADIX = RADIX_BITS'(16);

   // Long division: dividend bits retired per clock and cycles per digit
   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_CYCLES     = VALUE_BITS / BITS_PER_CYCLE;
   localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES);

   // Digit stack holds every digit of the widest magnitude in radix two
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

   // Queue between front and back (power of two depth)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_BITS-1:0] MINUS_SIGN = 8'h2D;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHARS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHARS_HIGH = 2'd2;

   // Reset values: radix ten, alphabet "0123456789abcdef"
   localparam logic [RADIX_BITS-1:0] RADIX_RESET      = RADIX_BITS'(10);
   localparam logic [WORD_BITS-1:0]  CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [WORD_BITS-1:0]  CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

   // One classified value on its way from front to back
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   // Clamp the programmed radix into the supported range
   function automatic logic [RADIX_BITS-1:0] sat_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < MIN_RADIX) begin
         res = MIN_RADIX;
      end else if (r > MAX_RADIX) begin
         res = MAX_RADIX;
      end
      return res;
   endfunction

   // Look up the character of one digit in the two alphabet words
   function automatic logic [CHAR_BITS-1:0] symbol_for(
      input logic [DIGIT_BITS-1:0] d,
      input logic [WORD_BITS-1:0]  lo,
      input logic [WORD_BITS-1:0]  hi
   );
      logic [WORD_BITS-1:0] word;
      word = d[DIGIT_BITS-1] ? hi : lo;
      return word[d[DIGIT_BITS-2:0]*CHAR_BITS +: CHAR_BITS];
   endfunction

endpackage

// ===== rtl/sitrd_front.sv =====
// Front stage: accepts input beats, splits sign and magnitude, registers the item.
module sitrd_front
   import sitrd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [VALUE_BITS-1:0] req_tdata,   // [31:0] value
   output logic                         item_valid,
   input  logic                         item_ready,
   output item_type                     item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [VALUE_BITS-1:0] raw;
   logic                  accept;

   // Take a new beat when the stage is empty or drains this cycle
   assign req_tready = !valid_ff || item_ready;
   assign accept     = req_tvalid && req_tready;

   // Classify: sign bit and two's complement magnitude
   always_comb begin
      raw         = VALUE_BITS'(unsigned'(req_tdata));
      item_in.neg = raw[VALUE_BITS-1];
      item_in.mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      valid_in    = accept ? 1'b1 : (item_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until it moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/sitrd_queue.sv =====
// Small FIFO that decouples the front stage from the digit engine.
module sitrd_queue
   import sitrd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/sitrd_back.sv =====
// Digit engine: long division by the radix, digit stack, and character output register.
module sitrd_back
   import sitrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RADIX_BITS-1:0] radix,
   input  logic [WORD_BITS-1:0]  chars_low,
   input  logic [WORD_BITS-1:0]  chars_high,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  item_type              item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_BITS-1:0]  rsp_tdata,   // [7:0] character
   output logic                  rsp_tlast    // last
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [VALUE_BITS-1:0]   shreg_ff, shreg_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    neg_ff, neg_in;
   logic [DIGIT_BITS-1:0]   stack_ff [STACK_DEPTH];
   logic [DIGIT_BITS-1:0]   stack_in [STACK_DEPTH];
   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]    out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;

   logic [RADIX_BITS-1:0]   radix_eff;
   logic [RADIX_BITS-1:0]   trial;
   logic [DIGIT_BITS-1:0]   rem_w;
   logic [VALUE_BITS-1:0]   sh_w;
   logic                    out_load;

   assign radix_eff  = sat_radix(radix);
   assign item_ready = (state_ff == ST_IDLE);
   assign out_load   = !out_valid_ff || rsp_tready;

   // Retire BITS_PER_CYCLE dividend bits: shift in, compare, subtract
   always_comb begin
      rem_w = rem_ff;
      sh_w  = shreg_ff;
      trial = '0;
      for (int j = 0; j < BITS_PER_CYCLE; j++) begin
         trial = {rem_w, sh_w[VALUE_BITS-1]};
         sh_w  = {sh_w[VALUE_BITS-2:0], 1'b0};
         if (trial >= radix_eff) begin
            trial   = trial - radix_eff;
            sh_w[0] = 1'b1;
         end
         rem_w = trial[DIGIT_BITS-1:0];
      end
   end

   // Sequence: load item, divide digit by digit, then emit sign and digits
   always_comb begin
      state_in     = state_ff;
      shreg_in     = shreg_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      stack_in     = stack_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               shreg_in = item.mag;
               neg_in   = item.neg;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            shreg_in = sh_w;
            rem_in   = rem_w;
            step_in  = step_ff + DIV_CNT_BITS'(1);
            if (step_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
               // Push the finished digit; quotient becomes the next dividend
               stack_in[0] = rem_w;
               for (int i = 1; i < STACK_DEPTH; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               count_in = count_ff + COUNT_BITS'(1);
               rem_in   = '0;
               step_in  = '0;
               if (sh_w == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               if (neg_ff) begin
                  out_char_in = MINUS_SIGN;
                  out_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  // Pop the most significant digit
                  out_char_in = symbol_for(stack_ff[0], chars_low, chars_high);
                  out_last_in = (count_ff == COUNT_BITS'(1));
                  for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                     stack_in[i] = stack_ff[i+1];
                  end
                  stack_in[STACK_DEPTH-1] = '0;
                  count_in = count_ff - COUNT_BITS'(1);
                  if (count_ff == COUNT_BITS'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      rem_ff      <= rem_in;
      stack_ff    <= stack_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/signed_int_to_radix_digits_core.sv =====
// Signed integer to radix text converter: top level with configuration registers.
//
// Usage: each beat on req_ (tdata = signed 32-bit value) yields a run of
// character beats on rsp_ (tdata = one 8-bit character), most significant
// digit first, preceded by '-' for a negative value; tlast marks the final
// character. Zero gives the single digit-zero character.
// csr_ writes radix (index 0, clamped to 2..16) and the two alphabet words
// (index 1: digits 0..7, index 2: digits 8..15, one byte each). csr_ready is
// always high; write only while no value is in flight.
// The front register and the queue pass each value to the digit engine, which
// runs the long divider (8 dividend bits a cycle) for each digit and then
// emits one character per cycle while rsp_tready is high.
// The front register and a two-entry queue take up to three further values
// while the engine works.
// Reset: radix 10, alphabet "0123456789abcdef", queue and engine empty.
// A stalled rsp_tready holds the current character; the engine waits on it.
module signed_int_to_radix_digits_core
   import sitrd_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic signed [VALUE_BITS-1:0]     req_tdata,   // [31:0] value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [CHAR_BITS-1:0]             rsp_tdata,   // [7:0] character
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [WORD_BITS-1:0]             csr_data
);

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [WORD_BITS-1:0]  chars_low_ff, chars_low_in;
   logic [WORD_BITS-1:0]  chars_high_ff, chars_high_in;

   logic     front_valid, front_ready;
   item_type front_item;
   logic     queue_valid, queue_ready;
   item_type queue_item;

   assign csr_ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      radix_in      = radix_ff;
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIX:      radix_in      = csr_data[RADIX_BITS-1:0];
            CSR_CHARS_LOW:  chars_low_in  = csr_data;
            CSR_CHARS_HIGH: chars_high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         chars_low_ff  <= CHARS_LOW_RESET;
         chars_high_ff <= CHARS_HIGH_RESET;
      end else begin
         radix_ff      <= radix_in;
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
      end
   end

   sitrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   sitrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   sitrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .radix      (radix_ff),
      .chars_low  (chars_low_ff),
      .chars_high (chars_high_ff),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/sitrd_checker.sv =====
// Port-level checker of the radix text converter, bound to the top level.
`include "signed_int_to_radix_digits_core_macros.svh"

module sitrd_checker
   import sitrd_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [CHAR_BITS-1:0]         rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   logic [2:0] pending_ff, pending_in;
   logic       in_beat, last_beat;

   assign in_beat   = req_tvalid && req_tready;
   assign last_beat = rsp_tvalid && rsp_tready && rsp_tlast;

   // Track values accepted but not yet finished
   always_comb begin
      pending_in = pending_ff;
      if (in_beat && !last_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (last_beat && !in_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SITRD_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid,
      "rsp_tvalid after reset")
   `SITRD_ASSERT_ALWAYS(a_reset_opens_req, clock, reset |=> req_tready,
      "req_tready low after reset")
   `SITRD_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tlast, rsp_tdata}),
      "stalled rsp beat changed")
   `SITRD_ASSERT(a_rsp_has_source, clock, reset, rsp_tvalid |-> pending_ff != 3'd0,
      "character without a pending value")
   `SITRD_ASSERT(a_csr_when_idle, clock, reset, csr_valid && csr_ready |-> pending_ff == 3'd0,
      "register write while a value is in flight")

endmodule

bind signed_int_to_radix_digits_core sitrd_checker u_checker (.*);

// ===== bench/tb_signed_int_to_radix_digits_core.sv =====
// Testbench for the signed integer to radix text converter core.
`timescale 1ns / 1ps

module tb_signed_int_to_radix_digits_core;
   import sitrd_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 6;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 31;

   // One expected character beat
   typedef struct {
      logic [CHAR_BITS-1:0] ch;
      logic                 last;
   } char_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic signed [VALUE_BITS-1:0]  req_tdata = '0;      // [31:0] value
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [CHAR_BITS-1:0]          rsp_tdata;           // [7:0] character
   logic                          rsp_tlast;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_RADIX;
   logic [WORD_BITS-1:0]          csr_data = '0;

   // Shadow copy of the configuration registers
   logic [RADIX_BITS-1:0]         cfg_radix      = RADIX_RESET;
   logic [WORD_BITS-1:0]          cfg_chars_low  = CHARS_LOW_RESET;
   logic [WORD_BITS-1:0]          cfg_chars_high = CHARS_HIGH_RESET;

   char_beat_type                 chars_due[$];
   int                            mismatch_count = 0;
   int                            values_sent = 0;
   int                            chars_checked = 0;
   int                            csr_writes = 0;
   logic [31:0]                   radix_seen = '0;
   logic                          steady = 1'b0;
   int                            rsp_wait = 0;
   int                            idle_cycles = 0;

   signed_int_to_radix_digits_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Print one mismatch line and count it
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // Work out the characters of one value under the current settings
   function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      int unsigned           base;
      int unsigned           digits[$];
      int unsigned           d;
      logic [WORD_BITS-1:0]  word;
      char_beat_type         beat;
      base = 32'(cfg_radix);
      if (cfg_radix < MIN_RADIX) begin
         base = 32'(MIN_RADIX);
      end else if (cfg_radix > MAX_RADIX) begin
         base = 32'(MAX_RADIX);
      end
      radix_seen[base] = 1'b1;
      mag = v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;
      if (v[VALUE_BITS-1]) begin
         beat.ch = MINUS_SIGN;
         beat.last = 1'b0;
         chars_due.push_back(beat);
      end
      // Peel off digits least significant first, emit most significant first
      do begin
         digits.push_front(mag % base);
         mag = mag / base;
      end while (mag != 0);
      foreach (digits[i]) begin
         d = digits[i];
         word = (d >= 8) ? cfg_chars_high : cfg_chars_low;
         beat.ch = word[(d % 8) * CHAR_BITS +: CHAR_BITS];
         beat.last = (i == digits.size() - 1);
         chars_due.push_back(beat);
      end
   endfunction

   // Send one value; predict its text when the beat is taken
   task automatic send_value(input logic [VALUE_BITS-1:0] v);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      predict_text(v);
      values_sent++;
   endtask

   // Hold off the sender until every expected character has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (chars_due.size() != 0) @(posedge clock);
   endtask

   // Write one configuration register; call only while drained
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [WORD_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RADIX:      cfg_radix = data[RADIX_BITS-1:0];
         CSR_CHARS_LOW:  cfg_chars_low = data;
         CSR_CHARS_HIGH: cfg_chars_high = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Radix write with random bits above the register width
   task automatic set_radix(input int unsigned r);
      logic [WORD_BITS-1:0] data;
      data = {$urandom, $urandom};
      data[RADIX_BITS-1:0] = RADIX_BITS'(r);
      write_register(CSR_RADIX, data);
   endtask

   // Random value biased toward short digit strings and the range ends
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 40);
         2: v = 32'h8000_0000 + $urandom_range(0, 3);
         3: v = 32'h7fff_ffff - $urandom_range(0, 3);
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) begin
         v = ~v + VALUE_BITS'(1);
      end
      return v;
   endfunction

   // Drive ready with a random stall after each taken beat
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each character beat with the oldest expectation
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_wait = steady ? 0 : $urandom_range(0, 3);
         chars_checked++;
         if (chars_due.size() == 0) begin
            report_mismatch($sformatf("unexpected character 8'h%02h", rsp_tdata));
         end else begin
            want = chars_due.pop_front();
            if (rsp_tdata !== want.ch) begin
               report_mismatch($sformatf("character 8'h%02h, want 8'h%02h",
                                         rsp_tdata, want.ch));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("tlast %b, want %b", rsp_tlast, want.last));
            end
         end
      end
   end

   // Abort when no channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("tb_signed_int_to_radix_digits_core: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset settings: radix ten and the stock alphabet
   task automatic test_reset_defaults();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hffff_ffff);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'd1_000_000_000);
      wait_drained();
   endtask

   // Radix register beyond both clamp limits and at the upper one
   task automatic test_radix_extremes();
      set_radix(0);
      send_value(32'h8000_0000);
      send_value(32'h7fff_ffff);
      send_value(32'hffff_ffff);
      wait_drained();
      set_radix(1);
      send_value(32'd5);
      wait_drained();
      set_radix(17);
      send_value(32'h8000_0000);
      wait_drained();
      set_radix(31);
      send_value(32'd255);
      wait_drained();
      set_radix(16);
      send_value(32'h7fff_ffff);
      send_value(32'h8000_0000);
      wait_drained();
   endtask

   // Alphabet words at all-zero, all-one and mixed content, every digit used
   task automatic test_alphabet();
      write_register(CSR_CHARS_LOW, '1);
      write_register(CSR_CHARS_HIGH, '0);
      send_value(32'h0fed_cba9);
      send_value(32'h7654_3210);
      wait_drained();
      write_register(CSR_CHARS_LOW, '0);
      write_register(CSR_CHARS_HIGH, '1);
      send_value(32'h0fed_cba9);
      send_value(32'h7654_3210);
      wait_drained();
      write_register(CSR_CHARS_LOW, 64'h5a3c_f00f_a55a_c3e1);
      write_register(CSR_CHARS_HIGH, 64'h1e2d_3c4b_5a69_7887);
      send_value(32'hf012_3456);
      send_value(32'h089a_bcde);
      wait_drained();
   endtask

   // Random values over phases of random settings
   task automatic test_random_phases();
      int unsigned r;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: r = 2;
            1: r = 16;
            2: r = 10;
            default: r = $urandom_range(0, 31);
         endcase
         set_radix(r);
         if ($urandom_range(0, 2) == 0) begin
            write_register(CSR_CHARS_LOW, CHARS_LOW_RESET);
            write_register(CSR_CHARS_HIGH, CHARS_HIGH_RESET);
         end else begin
            write_register(CSR_CHARS_LOW, {$urandom, $urandom});
            write_register(CSR_CHARS_HIGH, {$urandom, $urandom});
         end
         steady = (p == 2 || p == 7);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Let the converter run dry now and then
            if ((p == 3 && i == 15) || $urandom_range(0, 39) == 0) begin
               wait_drained();
            end
            send_value(random_value());
         end
         wait_drained();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_radix_extremes();
      test_alphabet();
      test_random_phases();

      // Drain, then watch for stray beats
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chars_due.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", chars_due.size()));
      end

      $display("converted %0d values into %0d characters over %0d register writes",
               values_sent, chars_checked, csr_writes);
      $display("distinct effective radixes exercised: %0d, mismatches: %0d",
               $countones(radix_seen), mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_signed_int_to_radix_digits_core: PASS");
      end else begin
         $display("tb_signed_int_to_radix_digits_core: FAIL");
      end
      $finish;
   end

endmodule
